### rtl/core/stcd_pkg.sv
// package for the seven-tooth crank decoder
// holds timestamp width, tooth constants and configuration register indexes
// no dependencies
package stcd_pkg;

    // timestamp width in bits
    localparam int TIME_BITS = 32;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W   = ((TIME_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 4 + 1 + 1 + 1 + 10 + 16 + TIME_BITS;
    localparam int M_TDATA_W   = ((OUT_FIELD_W + 7) / 8) * 8;

    // tooth geometry
    localparam int        TOOTH_DEG       = 360 / 6;
    localparam int        FIRST_TOOTH_DEG = 42;
    localparam logic [3:0] WRAP_ABOVE     = 4'd7;
    localparam logic [3:0] EXTRA_TOOTH    = 4'd3;

    // configuration register indexes
    localparam logic CFG_PER_TOOTH = 1'b0;
    localparam logic CFG_OFFSET    = 1'b1;

endpackage

### rtl/core/seven_tooth_crank_decoder.sv
// seven-tooth crank decoder: one result per tooth edge
// result is registered: it appears the cycle after the input transfer, and the register
// refills as its transfer completes; one tooth per cycle while m_axis_tready allows
// reset: synchronous active-low i_rst_n clears all tooth state, the
// configuration registers and the result valid flag
// depends on stcd_pkg
module seven_tooth_crank_decoder
    import stcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [7:0]           i_cfg_wdata,
    // tooth edge stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: tooth_time, then zero padding
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: tooth_number[3:0], in_sync, angle_correct, angle_valid,
    // crank_angle[9:0], revolution_count[15:0], current_gap, zero padding
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // configuration registers
    logic              r_per_tooth;
    logic signed [7:0] r_offset;

    // tooth state
    logic [TIME_BITS-1:0] r_last_time, n_last_time;
    logic [TIME_BITS-1:0] r_gap, n_gap;
    logic [1:0]           r_seen, n_seen;
    logic [3:0]           r_cnt, n_cnt;
    logic                 r_sync, n_sync;
    logic                 r_correct, n_correct;
    logic [15:0]          r_revs, n_revs;

    // result register
    logic                 r_out_valid;
    logic [3:0]           r_out_tooth;
    logic                 r_out_sync;
    logic                 r_out_correct;
    logic                 r_out_avalid;
    logic [9:0]           r_out_angle;
    logic [15:0]          r_out_revs;
    logic [TIME_BITS-1:0] r_out_gap;

    logic                 in_xfer;
    logic [TIME_BITS-1:0] now_time;
    logic [3:0]           cnt_inc;
    logic                 angle_ok;
    logic signed [11:0]   passed;
    logic signed [11:0]   angle_full;
    logic [9:0]           angle_out;

    // result register frees up in the cycle its transfer completes
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign now_time      = s_axis_tdata[TIME_BITS-1:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per_tooth <= 1'b0;
            r_offset    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PER_TOOTH: r_per_tooth <= i_cfg_wdata[0];
                CFG_OFFSET:    r_offset    <= i_cfg_wdata;
                default:       r_per_tooth <= r_per_tooth;
            endcase
        end
    end

    // tooth counter, gap test and sync tracking
    always_comb begin
        n_last_time = now_time;
        n_gap       = now_time - r_last_time;
        cnt_inc     = r_cnt + 4'd1;
        n_cnt       = cnt_inc;
        n_sync      = r_sync;
        n_correct   = r_correct;
        n_revs      = r_revs;
        n_seen      = (r_seen == 2'd2) ? r_seen : r_seen + 2'd1;
        if (r_seen == 2'd2) begin
            if (cnt_inc > WRAP_ABOVE) begin
                n_cnt     = 4'd1;
                n_correct = 1'b1;
            end else if (n_gap < (r_gap >> 1)) begin
                n_cnt     = EXTRA_TOOTH;
                n_sync    = 1'b1;
                n_correct = 1'b0;
                n_revs    = r_revs + 16'd1;
            end else begin
                n_correct = 1'b1;
            end
        end
    end

    // per-tooth angle, skipping the extra tooth
    always_comb begin
        angle_ok = r_per_tooth && (n_cnt != EXTRA_TOOTH);
        if (n_cnt < EXTRA_TOOTH) begin
            passed = $signed({8'd0, n_cnt}) - 12'sd1;
        end else begin
            passed = $signed({8'd0, n_cnt}) - 12'sd2;
        end
        angle_full = passed * 12'(TOOTH_DEG) + 12'(FIRST_TOOTH_DEG)
                     + {{4{r_offset[7]}}, r_offset};
        angle_out  = angle_ok ? angle_full[9:0] : 10'd0;
    end

    // state update on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_gap       <= '0;
            r_seen      <= '0;
            r_cnt       <= '0;
            r_sync      <= 1'b0;
            r_correct   <= 1'b0;
            r_revs      <= '0;
        end else if (in_xfer) begin
            r_last_time <= n_last_time;
            r_gap       <= n_gap;
            r_seen      <= n_seen;
            r_cnt       <= n_cnt;
            r_sync      <= n_sync;
            r_correct   <= n_correct;
            r_revs      <= n_revs;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_tooth   <= n_cnt;
            r_out_sync    <= n_sync;
            r_out_correct <= n_correct;
            r_out_avalid  <= angle_ok;
            r_out_angle   <= angle_out;
            r_out_revs    <= n_revs;
            r_out_gap     <= n_gap;
        end
    end

    // pack the result fields
    always_comb begin
        m_axis_tdata                     = '0;
        m_axis_tdata[3:0]                = r_out_tooth;
        m_axis_tdata[4]                  = r_out_sync;
        m_axis_tdata[5]                  = r_out_correct;
        m_axis_tdata[6]                  = r_out_avalid;
        m_axis_tdata[16:7]               = r_out_angle;
        m_axis_tdata[32:17]              = r_out_revs;
        m_axis_tdata[33+TIME_BITS-1:33]  = r_out_gap;
    end

    assign m_axis_tvalid = r_out_valid;

`ifndef SYNTH
    // once two teeth are seen the counter stays within one to seven
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_seen == 2'd2) |=> (r_cnt >= 4'd1 && r_cnt <= WRAP_ABOVE))
        else $error("tooth counter left its range after sync window");

    // a valid angle is never reported on the extra tooth
    a_angle_tooth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_avalid) |-> (r_out_tooth != EXTRA_TOOTH))
        else $error("angle marked valid on extra tooth");

    // invalid angle reads as zero
    a_angle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_avalid) |-> (r_out_angle == 10'd0))
        else $error("crank angle not zero while invalid");

    // revolution count moves only on the extra tooth with sync set
    a_rev_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_revs != $past(r_revs))
            |-> (r_cnt == EXTRA_TOOTH && r_sync && !r_correct))
        else $error("revolution count changed off the extra tooth");
`endif

endmodule
